/* hdl/rrbf_pkg.sv */
// Shared constants, control and status types and the divide-by-fifteen helper
// for the RGBA4444 rectangle blend-fill block. Depends on nothing.
`timescale 1ns / 1ps
package rrbf_pkg;

  localparam int FB_WIDTH_DEF  = 640;
  localparam int FB_HEIGHT_DEF = 360;

  localparam int         CRD_W     = 11;
  localparam logic [3:0] NIB_MASK  = 4'hF;
  localparam int         ALPHA_LSB = 12;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic setup;
    logic step;
    logic rd;
    logic capture;
  } rrbf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pix_last;
    logic is_read;
    logic empty;
  } rrbf_stat_t;

  // floor(v / 15) for v up to 225, by multiplication with 137 / 2048.
  function automatic logic [3:0] div15(input logic [7:0] v);
    logic [15:0] p;
    p = {8'b0, v} * 16'd137;
    return p[14:11];
  endfunction

endpackage

/* hdl/rrbf_dp.sv */
// Datapath of the blend-fill block: clipping, address counters, frame memory and the
// three-stage read-blend-write pipeline. Depends on rrbf_pkg.
`timescale 1ns / 1ps
module rrbf_dp
  import rrbf_pkg::*;
#(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rrbf_cmd_t               cmd,
  output rrbf_stat_t              stat,
  input  logic                    in_operation,
  input  logic signed [11:0]      in_pos_x,
  input  logic signed [11:0]      in_pos_y,
  input  logic [10:0]             in_rect_width,
  input  logic [10:0]             in_rect_height,
  input  logic [15:0]             in_fill_color,
  output logic [15:0]             out_pixel_data,
  output logic                    out_in_range
);

  localparam int DEPTH  = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [13:0] W14 = 14'(FB_WIDTH);
  localparam logic signed [13:0] H14 = 14'(FB_HEIGHT);

  logic [15:0] frame_mem [DEPTH];

  logic              op_r;
  logic [15:0]       color_r;
  logic [CRD_W-1:0]  x0_r, xl_r, y0_r, yl_r;
  logic              empty_r, rd_ok_r;
  logic [CRD_W-1:0]  col_r, row_r;
  logic [ADDR_W-1:0] base_r, clr_addr_r;
  logic [ADDR_W-1:0] iss_addr;
  logic [15:0]       rd_data_r;
  logic              a_v_r, b_v_r;
  logic [ADDR_W-1:0] a_addr_r, b_addr_r;
  logic [7:0]        sum_r [3];
  logic [3:0]        alpha, inv_alpha;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [15:0]       mixed_px;

  logic signed [13:0] sx, sy, xe, ye, x0s, y0s, x1s, y1s, xls, yls;
  logic               fill_empty, read_ok;

  always_comb begin
    sx  = 14'(in_pos_x);
    sy  = 14'(in_pos_y);
    xe  = sx + $signed({3'b0, in_rect_width});
    ye  = sy + $signed({3'b0, in_rect_height});
    x0s = sx[13] ? 14'sd0 : sx;
    y0s = sy[13] ? 14'sd0 : sy;
    x1s = (xe > W14) ? W14 : xe;
    y1s = (ye > H14) ? H14 : ye;
    xls = x1s - 14'sd1;
    yls = y1s - 14'sd1;
    fill_empty = (x1s <= x0s) || (y1s <= y0s) ||
                 (in_fill_color[ALPHA_LSB +: 4] == 4'h0);
    read_ok = !sx[13] && (sx < W14) && !sy[13] && (sy < H14);
  end

  assign alpha     = color_r[ALPHA_LSB +: 4];
  assign inv_alpha = NIB_MASK - alpha;
  assign iss_addr  = base_r + ADDR_W'(col_r);

  assign stat.clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign stat.pix_last = (col_r == xl_r) && (row_r == yl_r);
  assign stat.is_read  = (op_r == OP_READ);
  assign stat.empty    = empty_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      color_r <= in_fill_color;
      x0_r    <= x0s[CRD_W-1:0];
      y0_r    <= y0s[CRD_W-1:0];
      xl_r    <= xls[CRD_W-1:0];
      yl_r    <= yls[CRD_W-1:0];
      empty_r <= fill_empty;
      rd_ok_r <= read_ok;
    end
    if (cmd.setup) begin
      base_r <= ADDR_W'(ADDR_W'(y0_r) * ADDR_W'(FB_WIDTH));
      col_r  <= x0_r;
      row_r  <= y0_r;
    end else if (cmd.step) begin
      if (col_r == xl_r) begin
        col_r  <= x0_r;
        row_r  <= row_r + 1'b1;
        base_r <= base_r + ADDR_W'(FB_WIDTH);
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (cmd.capture) begin
      out_pixel_data <= (op_r == OP_READ && rd_ok_r) ? rd_data_r : 16'h0000;
      out_in_range   <= (op_r == OP_READ) && rd_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      a_v_r <= cmd.step;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= iss_addr;
    b_addr_r <= a_addr_r;
    for (int c = 0; c < 3; c++) begin
      sum_r[c] <= 8'(color_r[4*c +: 4]) * 8'(alpha) +
                  8'(rd_data_r[4*c +: 4]) * 8'(inv_alpha);
    end
  end

  assign mixed_px = {NIB_MASK, div15(sum_r[2]), div15(sum_r[1]), div15(sum_r[0])};

  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 16'h0000;
    end else begin
      mem_we    = b_v_r;
      mem_waddr = b_addr_r;
      mem_wdata = (alpha == NIB_MASK) ? color_r : mixed_px;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd || cmd.step) begin
      rd_data_r <= frame_mem[iss_addr];
    end
  end

endmodule

/* hdl/rrbf_ctrl.sv */
// Controller of the blend-fill block: clearing pass, item sequencing and result strobe.
// Depends on rrbf_pkg.
`timescale 1ns / 1ps
module rrbf_ctrl
  import rrbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  output rrbf_cmd_t  cmd,
  input  rrbf_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_READ,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.is_read) state_nxt = ST_READ;
        else if (stat.empty) state_nxt = ST_RESP;
        else state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.step = 1'b1;
        if (stat.pix_last) state_nxt = ST_DRAIN1;
      end
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_RESP;
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_RESP);
    end
  end

endmodule

/* hdl/rgba4444_rect_blend_fill.sv */
// After reset the block sweeps the frame memory to zero, one pixel a cycle, over
// all FB_WIDTH*FB_HEIGHT pixels (230400 by default) with busy high.
// A read item passes the setup, read and response states; its strobe comes back in idle.
// A fill item steps through its N clipped pixels, one pixel a cycle through the
// read-modify-write port of the frame memory, then drains; an empty fill skips the steps.
// Every item gives one result, strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module rgba4444_rect_blend_fill
  import rrbf_pkg::*;
#(
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [10:0]        in_rect_width,
  input  logic [10:0]        in_rect_height,
  input  logic [15:0]        in_fill_color,
  output logic               out_valid,
  output logic [15:0]        out_pixel_data,
  output logic               out_in_range
);

  rrbf_cmd_t  cmd;
  rrbf_stat_t stat;

  rrbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  rrbf_dp #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_fill_color  (in_fill_color),
    .out_pixel_data (out_pixel_data),
    .out_in_range   (out_in_range)
  );

endmodule

/* sim/tb_rgba4444_rect_blend_fill.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rgba4444_rect_blend_fill: drives fill and read items,
// mirrors the frame store in a small scoreboard and checks every result item.
// Depends on rrbf_pkg and the block's RTL.
module tb_rgba4444_rect_blend_fill
  import rrbf_pkg::*;
();

  localparam int FB_W          = FB_WIDTH_DEF;
  localparam int FB_H          = FB_HEIGHT_DEF;
  localparam int RANDOM_ITEMS  = 840;
  localparam int WIDE_AREA_MAX = 1024;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_MAX     = 200;

  typedef struct {
    logic               op;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [15:0]        color;
  } draw_cmd_t;

  typedef struct {
    int          seq;
    logic [15:0] pixel;
    logic        in_range;
  } readback_t;

  class frame_mirror;
    bit [15:0] pixels [FB_W * FB_H];
    readback_t pending_pixels [$];
    int        items_noted;
    int        errors;

    function void report(string msg);
      errors++;
      if (errors <= PRINT_MAX) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function int clip_rect(input draw_cmd_t c, output int x0, output int y0,
                           output int x1, output int y1);
      x0 = (c.x < 0) ? 0 : int'(c.x);
      y0 = (c.y < 0) ? 0 : int'(c.y);
      x1 = int'(c.x) + int'(c.w);
      y1 = int'(c.y) + int'(c.h);
      if (x1 > FB_W) x1 = FB_W;
      if (y1 > FB_H) y1 = FB_H;
      if (x1 <= x0 || y1 <= y0) return 0;
      return (x1 - x0) * (y1 - y0);
    endfunction

    function logic [15:0] blend_pixel(logic [15:0] dst, logic [15:0] src, logic [3:0] a);
      logic [15:0] res;
      int          mix;
      res = {NIB_MASK, 12'h000};
      for (int k = 0; k < 12; k += 4) begin
        mix = (int'(src[k +: 4]) * int'(a) + int'(dst[k +: 4]) * (int'(NIB_MASK) - int'(a)))
              / int'(NIB_MASK);
        res[k +: 4] = 4'(mix);
      end
      return res;
    endfunction

    function void paint_rect(draw_cmd_t c);
      int         x0, y0, x1, y1;
      logic [3:0] a;
      a = c.color[ALPHA_LSB +: 4];
      if (a == 4'h0 || clip_rect(c, x0, y0, x1, y1) == 0) return;
      for (int j = y0; j < y1; j++) begin
        for (int i = x0; i < x1; i++) begin
          if (a == NIB_MASK) begin
            pixels[j * FB_W + i] = c.color;
          end else begin
            pixels[j * FB_W + i] = blend_pixel(pixels[j * FB_W + i], c.color, a);
          end
        end
      end
    endfunction

    function void note_item(draw_cmd_t c);
      readback_t r;
      r.seq      = items_noted++;
      r.pixel    = 16'h0000;
      r.in_range = 1'b0;
      if (c.op == OP_FILL) begin
        paint_rect(c);
      end else if (c.x >= 0 && c.x < FB_W && c.y >= 0 && c.y < FB_H) begin
        r.pixel    = pixels[int'(c.y) * FB_W + int'(c.x)];
        r.in_range = 1'b1;
      end
      pending_pixels.push_back(r);
    endfunction

    function void check_pixel(logic [15:0] pix, logic rng);
      readback_t e;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected result pixel_data=%h in_range=%b", pix, rng));
        return;
      end
      e = pending_pixels.pop_front();
      if (pix !== e.pixel) begin
        report($sformatf("item %0d pixel_data %h, expected %h", e.seq, pix, e.pixel));
      end
      if (rng !== e.in_range) begin
        report($sformatf("item %0d in_range %b, expected %b", e.seq, rng, e.in_range));
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic signed [11:0] in_pos_x;
  logic signed [11:0] in_pos_y;
  logic [10:0]        in_rect_width;
  logic [10:0]        in_rect_height;
  logic [15:0]        in_fill_color;
  logic               out_valid;
  logic [15:0]        out_pixel_data;
  logic               out_in_range;

  frame_mirror mirror = new;
  int          cycle_count = 0;
  int          hot_x0 = 0;
  int          hot_y0 = 0;
  int          hot_x1 = FB_W;
  int          hot_y1 = FB_H;

  rgba4444_rect_blend_fill #(
    .FB_WIDTH (FB_W),
    .FB_HEIGHT(FB_H)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .in_fill_color (in_fill_color),
    .out_valid     (out_valid),
    .out_pixel_data(out_pixel_data),
    .out_in_range  (out_in_range)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** rgba4444_rect_blend_fill: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      mirror.check_pixel(out_pixel_data, out_in_range);
    end
  end

  function automatic draw_cmd_t make_cmd(logic op, int x, int y, int w, int h,
                                         logic [15:0] color);
    draw_cmd_t c;
    c.op    = op;
    c.x     = 12'(x);
    c.y     = 12'(y);
    c.w     = 11'(w);
    c.h     = 11'(h);
    c.color = color;
    return c;
  endfunction

  function automatic int near_border(int span);
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 40)) - 20;
      1: return span - 20 + int'($urandom_range(0, 40));
      default: return int'($urandom_range(0, span - 1));
    endcase
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        x0, y0, x1, y1, pick;
    pick    = $urandom_range(0, 99);
    c.op    = OP_FILL;
    c.x     = 12'($urandom);
    c.y     = 12'($urandom);
    c.w     = 11'($urandom);
    c.h     = 11'($urandom);
    c.color = 16'($urandom);
    if (pick < 40) begin
      c.op = OP_READ;
      if (pick < 32) begin
        c.x = 12'($urandom_range(hot_x0, hot_x1 - 1));
        c.y = 12'($urandom_range(hot_y0, hot_y1 - 1));
      end
    end else if (pick < 92) begin
      c.x = 12'(near_border(FB_W));
      c.y = 12'(near_border(FB_H));
      c.w = 11'($urandom_range(0, 24));
      c.h = 11'($urandom_range(0, 24));
      case ($urandom_range(0, 9))
        0: c.color[ALPHA_LSB +: 4] = 4'h0;
        1, 2: c.color[ALPHA_LSB +: 4] = NIB_MASK;
        default: ;
      endcase
    end else begin
      // Full-range geometry, redrawn until the clipped area stays modest.
      while (mirror.clip_rect(c, x0, y0, x1, y1) > WIDE_AREA_MAX) begin
        c.x = 12'($urandom);
        c.y = 12'($urandom);
      end
    end
    return c;
  endfunction

  task automatic send_item(draw_cmd_t c, int idle_pct);
    int x0, y0, x1, y1;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start          <= 1'b1;
    in_operation   <= c.op;
    in_pos_x       <= c.x;
    in_pos_y       <= c.y;
    in_rect_width  <= c.w;
    in_rect_height <= c.h;
    in_fill_color  <= c.color;
    do @(posedge clk); while (busy);
    mirror.note_item(c);
    if (c.op == OP_FILL && c.color[ALPHA_LSB +: 4] != 4'h0 &&
        mirror.clip_rect(c, x0, y0, x1, y1) > 0) begin
      hot_x0 = x0;
      hot_y0 = y0;
      hot_x1 = x1;
      hot_y1 = y1;
    end
  endtask

  initial begin
    int phase_idle [4];
    phase_idle     = '{0, 76, 0, 24};
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_FILL;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_rect_width  = '0;
    in_rect_height = '0;
    in_fill_color  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, -3, -2, 8, 6, 16'hF123), 0);
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, 0, 0, 5, 5, 16'h0FFF), 0);
    send_item(make_cmd(OP_READ, 1, 1, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, 2, 2, 4, 4, 16'h7ABC), 0);
    send_item(make_cmd(OP_READ, 2, 2, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_READ, 5, 4, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, FB_W - 4, FB_H - 3, 10, 10, 16'hFFFF), 0);
    send_item(make_cmd(OP_FILL, FB_W - 10, FB_H - 10, 20, 20, 16'h1000), 0);
    send_item(make_cmd(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_READ, FB_W - 10, FB_H - 10, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, 10, 10, 0, 5, 16'hF00F), 0);
    send_item(make_cmd(OP_FILL, 10, 10, 5, 0, 16'hF00F), 0);
    send_item(make_cmd(OP_READ, 10, 10, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_FILL, -2048, -2048, 2047, 2047, 16'hFFFF), 0);
    send_item(make_cmd(OP_FILL, 2047, 2047, 2047, 2047, 16'hFFFF), 0);
    send_item(make_cmd(OP_READ, -1, 0, 2047, 2047, 16'hFFFF), 0);
    send_item(make_cmd(OP_READ, 0, -1, 2047, 2047, 16'hFFFF), 0);
    send_item(make_cmd(OP_READ, FB_W, 0, 0, 0, 16'hFFFF), 0);
    send_item(make_cmd(OP_READ, 0, FB_H, 0, 0, 16'hFFFF), 0);
    send_item(make_cmd(OP_READ, -2048, 2047, 2047, 2047, 16'hFFFF), 0);
    send_item(make_cmd(OP_FILL, -100, -100, 2047, 2047, 16'h8421), 0);
    send_item(make_cmd(OP_READ, FB_W / 2, FB_H / 2, 0, 0, 16'h0000), 0);
    send_item(make_cmd(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 16'h0000), 0);

    foreach (phase_idle[p]) begin
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        send_item(random_cmd(), phase_idle[p]);
      end
    end
    start <= 1'b0;

    while (mirror.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("** rgba4444_rect_blend_fill: PASSED **");
    end else begin
      $display("** rgba4444_rect_blend_fill: FAILED **");
    end
    $finish;
  end

endmodule
